// ===== rtl/jerk_limited_step_profile_core_macros.svh =====
// Assertion macros for the jerk-limited step profile core.
`ifndef JERK_LIMITED_STEP_PROFILE_CORE_MACROS_SVH
`define JERK_LIMITED_STEP_PROFILE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define JLSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JLSP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define JLSP_ASSERT(lbl, prop, msg)
`define JLSP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/jlsp_pkg.sv =====
// Package with types and constants of the jerk-limited step profile core.
`timescale 1ns / 1ps
package jlsp_pkg;
  localparam int STEP_COUNT_BITS = 24;
  localparam int POSITION_BITS = 32;
  localparam int RAMP_BITS = STEP_COUNT_BITS + 16;
  localparam int SHORT_MOVE_LIMIT = 2000;
  localparam logic [31:0] PERIOD_NUMERATOR = 32'd2867200000;
  localparam logic [19:0] PERIOD_MAX = 20'hFFFFF;

  localparam logic [31:0] RST_MIN_SPEED = 32'd409600;
  localparam logic [31:0] RST_MAX_SPEED = 32'd4096000;
  localparam logic [31:0] RST_MAX_JERK = 32'd409600000;
  localparam logic [31:0] RST_MAX_ACCEL = 32'd40960000;
  localparam logic [15:0] RST_LONG_RATIO = 16'd16384;
  localparam logic [15:0] RST_SHORT_RATIO = 16'd32768;

  localparam logic [2:0] CFG_MIN_SPEED = 3'd0;
  localparam logic [2:0] CFG_MAX_SPEED = 3'd1;
  localparam logic [2:0] CFG_MAX_JERK = 3'd2;
  localparam logic [2:0] CFG_MAX_ACCEL = 3'd3;
  localparam logic [2:0] CFG_LONG_RATIO = 3'd4;
  localparam logic [2:0] CFG_SHORT_RATIO = 3'd5;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MULJ,
    ST_ACC,
    ST_MULA,
    ST_SPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept_start;
    logic accept_idle;
    logic accept_run;
    logic div_step;
    logic take_period;
    logic mul_jerk;
    logic acc_upd;
    logic mul_acc;
    logic spd_upd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic move_active;
    logic div_last;
  } stat_t;
endpackage

// ===== rtl/jlsp_ctrl.sv =====
// Controller state machine of the jerk-limited step profile core.
`timescale 1ns / 1ps
module jlsp_ctrl import jlsp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  req_type_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_START) begin
            cmd_o.accept_start = 1'b1;
            state_d = ST_DONE;
          end else if (stat_i.move_active) begin
            cmd_o.accept_run = 1'b1;
            state_d = ST_DIV;
          end else begin
            cmd_o.accept_idle = 1'b1;
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_MULJ;
      end
      ST_MULJ: begin
        cmd_o.take_period = 1'b1;
        cmd_o.mul_jerk = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_upd = 1'b1;
        state_d = ST_MULA;
      end
      ST_MULA: begin
        cmd_o.mul_acc = 1'b1;
        state_d = ST_SPD;
      end
      ST_SPD: begin
        cmd_o.spd_upd = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
endmodule

// ===== rtl/jlsp_datapath.sv =====
// Datapath of the jerk-limited step profile core: registers, divider, multiplier.
`timescale 1ns / 1ps
module jlsp_datapath import jlsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [23:0]        step_count_i,
  input  logic               move_direction_i,
  input  logic [31:0]        time_step_frac_i,
  output logic [19:0]        step_period_us_o,
  output logic               dir_pin_level_o,
  output logic signed [31:0] step_position_o,
  output logic               last_step_o,
  output logic               status_o
);
  logic [31:0] min_speed_q, max_speed_q, max_jerk_q, max_accel_q;
  logic [15:0] long_ratio_q, short_ratio_q;

  logic [POSITION_BITS-1:0]   position_q;
  logic [STEP_COUNT_BITS-1:0] index_q, total_q;
  logic [RAMP_BITS-1:0]       ramp_q;
  logic [31:0]                accel_q, speed_q, dt_q;
  logic                       dir_q, active_q;

  logic [31:0] rem_q, quo_q, divisor_q, mul_q;
  logic [4:0]  cnt_q;
  logic [19:0] res_period_q;
  logic        res_last_q, res_status_q;
  logic [19:0] out_period_q;
  logic        out_dir_q, out_last_q, out_status_q;
  logic [31:0] out_pos_q;

  logic [STEP_COUNT_BITS-1:0] n_in, index_next;
  logic [15:0]                ratio;
  logic [32:0]                trial;
  logic                       ge;
  logic [RAMP_BITS-1:0]       i16, n16;
  logic [RAMP_BITS:0]         i17, n17_less_ramp;
  logic                       ph_up, ph_down, use_up;
  logic [32:0]                acc_sum, spd_sum;
  logic [31:0]                acc_new, spd_new;
  logic [63:0]                product;

  assign n_in  = STEP_COUNT_BITS'(step_count_i);
  assign ratio = (n_in < STEP_COUNT_BITS'(SHORT_MOVE_LIMIT)) ? short_ratio_q : long_ratio_q;

  assign trial = {rem_q, PERIOD_NUMERATOR[5'd31 - cnt_q]};
  assign ge    = (trial >= {1'b0, divisor_q});

  assign i16 = {index_q, 16'b0};
  assign n16 = {total_q, 16'b0};
  assign i17 = {index_q, 17'b0};
  assign n17_less_ramp = {total_q, 17'b0} - {1'b0, ramp_q};
  assign ph_up   = (i16 < ramp_q);
  assign ph_down = (({1'b0, i16} + {1'b0, ramp_q}) >= {1'b0, n16});
  assign use_up  = ph_up ? (i17 < {1'b0, ramp_q}) : (i17 < n17_less_ramp);

  assign product = 64'(cmd_i.mul_jerk ? max_jerk_q : accel_q) * 64'(dt_q);
  assign index_next = index_q + 1'b1;

  always_comb begin
    acc_sum = {1'b0, accel_q} + {1'b0, mul_q};
    spd_sum = {1'b0, speed_q} + {1'b0, mul_q};
    if (use_up) begin
      acc_new = (acc_sum > {1'b0, max_accel_q}) ? max_accel_q : acc_sum[31:0];
    end else begin
      acc_new = (accel_q > mul_q) ? accel_q - mul_q : 32'd0;
    end
    if (ph_up) begin
      spd_new = (spd_sum > {1'b0, max_speed_q}) ? max_speed_q : spd_sum[31:0];
    end else if ((speed_q < mul_q) || ((speed_q - mul_q) < min_speed_q)) begin
      spd_new = min_speed_q;
    end else begin
      spd_new = speed_q - mul_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q   <= RST_MIN_SPEED;
      max_speed_q   <= RST_MAX_SPEED;
      max_jerk_q    <= RST_MAX_JERK;
      max_accel_q   <= RST_MAX_ACCEL;
      long_ratio_q  <= RST_LONG_RATIO;
      short_ratio_q <= RST_SHORT_RATIO;
      position_q    <= '0;
      index_q       <= '0;
      total_q       <= '0;
      ramp_q        <= '0;
      accel_q       <= '0;
      speed_q       <= RST_MIN_SPEED;
      dt_q          <= '0;
      dir_q         <= 1'b0;
      active_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MIN_SPEED:   min_speed_q   <= cfg_data_i;
          CFG_MAX_SPEED:   max_speed_q   <= cfg_data_i;
          CFG_MAX_JERK:    max_jerk_q    <= cfg_data_i;
          CFG_MAX_ACCEL:   max_accel_q   <= cfg_data_i;
          CFG_LONG_RATIO:  long_ratio_q  <= cfg_data_i[15:0];
          CFG_SHORT_RATIO: short_ratio_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.accept_start) begin
        total_q  <= n_in;
        dir_q    <= move_direction_i;
        dt_q     <= time_step_frac_i;
        ramp_q   <= RAMP_BITS'(n_in) * RAMP_BITS'(ratio);
        index_q  <= '0;
        accel_q  <= '0;
        speed_q  <= min_speed_q;
        active_q <= (n_in != '0);
      end
      if (cmd_i.acc_upd && (ph_up || ph_down)) accel_q <= acc_new;
      if (cmd_i.spd_upd) begin
        if (ph_up || ph_down) speed_q <= spd_new;
        position_q <= dir_q ? position_q + 1'b1 : position_q - 1'b1;
        index_q    <= index_next;
        if (index_next == total_q) active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_run) begin
      rem_q     <= '0;
      quo_q     <= '0;
      cnt_q     <= '0;
      divisor_q <= speed_q;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? 32'(trial - {1'b0, divisor_q}) : trial[31:0];
      quo_q <= {quo_q[30:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.mul_jerk || cmd_i.mul_acc) mul_q <= product[63:32];
    if (cmd_i.take_period) begin
      res_period_q <= (quo_q > 32'(PERIOD_MAX)) ? PERIOD_MAX : quo_q[19:0];
    end
    if (cmd_i.accept_start || cmd_i.accept_idle) begin
      res_period_q <= '0;
      res_last_q   <= 1'b0;
      res_status_q <= cmd_i.accept_idle;
    end
    if (cmd_i.spd_upd) begin
      res_last_q   <= (index_next == total_q);
      res_status_q <= 1'b0;
    end
    if (cmd_i.load_out) begin
      out_period_q <= res_period_q;
      out_dir_q    <= ~dir_q;
      out_pos_q    <= 32'(position_q);
      out_last_q   <= res_last_q;
      out_status_q <= res_status_q;
    end
  end

  assign stat_o.move_active = active_q;
  assign stat_o.div_last    = (cnt_q == 5'd31);

  assign step_period_us_o = out_period_q;
  assign dir_pin_level_o  = out_dir_q;
  assign step_position_o  = out_pos_q;
  assign last_step_o      = out_last_q;
  assign status_o         = out_status_q;
endmodule

// ===== rtl/jerk_limited_step_profile_core.sv =====
// Top level of the jerk-limited step profile core.
// A step transaction of an active move runs from acceptance through the bit-serial period
// divider, then the multiply and update states ST_MULJ, ST_ACC, ST_MULA and ST_SPD, then
// the result load. A start transaction or a step with no active move goes straight to
// the load. One transaction is in work at a time; the load waits while an earlier result
// is not taken. Asynchronous active-low reset restores the defaults.
`timescale 1ns / 1ps
`include "jerk_limited_step_profile_core_macros.svh"
module jerk_limited_step_profile_core import jlsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [23:0]        step_count_i,
  input  logic               move_direction_i,
  input  logic [31:0]        time_step_frac_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [19:0]        step_period_us_o,
  output logic               dir_pin_level_o,
  output logic signed [31:0] step_position_o,
  output logic               last_step_o,
  output logic               status_o
);
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  jlsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  jlsp_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .step_count_i     (step_count_i),
    .move_direction_i (move_direction_i),
    .time_step_frac_i (time_step_frac_i),
    .step_period_us_o (step_period_us_o),
    .dir_pin_level_o  (dir_pin_level_o),
    .step_position_o  (step_position_o),
    .last_step_o      (last_step_o),
    .status_o         (status_o)
  );

  `JLSP_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready after accept")
  `JLSP_ASSERT_NEVER(a_last_and_error, out_valid_o && last_step_o && status_o, "last step with error")
  `JLSP_ASSERT(a_error_period, out_valid_o && status_o |-> step_period_us_o == 20'd0, "error period")
endmodule
